FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the design files.
// Each macro checks on the rising edge of clk and is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in the same cycle.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

FILE: design/skf3_pkg.sv
// ----------------------------------------------------------------------------
// skf3_pkg
// Types and fixed constants of the three-axis scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf3_pkg;

    localparam int AXIS_W     = 2;
    localparam int MEAS_W     = 16;
    localparam int EST_W      = 32;
    localparam int VAR_W      = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // The multiplier takes its second operand in two halves of this split.
    localparam int MUL_OPB_W  = 34;
    localparam int MUL_SPLIT  = 17;

    // Register indexes, decoded from paddr[2].
    typedef enum logic {
        REG_PROCESS_NOISE     = 1'b0,
        REG_MEASUREMENT_NOISE = 1'b1
    } skf3_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DENOM,
        ST_DIV,
        ST_MUL_E_LO,
        ST_MUL_E_HI,
        ST_EST,
        ST_MUL_C_LO,
        ST_MUL_C_HI,
        ST_COV
    } skf3_state_t;

endpackage

FILE: design/scalar_kalman_filter_three_axis.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter, three axes: one restoring divider and one shared multiplier.
// One item is in work at a time: a new input is taken only once the block is idle again.
// The gain division is restoring and bit-serial, one quotient bit per cycle.
// Reset gives estimates 0, covariances 0.02 and the noise registers their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scalar_kalman_filter_three_axis
    import skf3_pkg::*;
#(
    parameter int NUM_AXES      = 3,
    parameter int VAR_FRAC_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,

    input  logic                         meas_valid,
    output logic                         meas_stall,
    input  logic [AXIS_W-1:0]            axis,
    input  logic signed [MEAS_W-1:0]     measurement,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [AXIS_W-1:0]            axis_out,
    output logic signed [EST_W-1:0]      estimate,
    output logic [VAR_FRAC_BITS:0]       gain
);

    // ------------------------------------------------------------------------
    // Derived sizes and constants.
    // ------------------------------------------------------------------------
    localparam int GAIN_W = VAR_FRAC_BITS + 1;
    localparam int AX_W   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int CNT_W  = $clog2(VAR_FRAC_BITS + 1);
    localparam int DEN_W  = VAR_W + 1;
    localparam int REM_W  = VAR_W + 2;
    localparam int HALF_W = MUL_SPLIT + 1;
    localparam int PROD_W = GAIN_W + 1 + HALF_W;
    localparam int ACC_W  = VAR_FRAC_BITS + 36;

    localparam logic [63:0] ONE64 = 64'd1 << VAR_FRAC_BITS;
    localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {VAR_FRAC_BITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(ONE64 >> 1);
    localparam logic [VAR_W-1:0] COV_RESET = VAR_W'(ONE64 * 2 / 100);
    localparam logic [VAR_W-1:0] PN_RESET  = VAR_W'(ONE64 / 1000);
    localparam logic [VAR_W-1:0] MN_RESET  = VAR_W'(ONE64 * 543 / 1000);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(VAR_FRAC_BITS);

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    skf3_state_t                 state_reg, state_next;

    logic [VAR_W-1:0]            pn_reg;
    logic [VAR_W-1:0]            mn_reg;

    logic signed [EST_W-1:0]     est_mem_reg [NUM_AXES];
    logic [VAR_W-1:0]            cov_mem_reg [NUM_AXES];

    logic [AXIS_W-1:0]           axis_reg, axis_next;
    logic signed [MEAS_W-1:0]    meas_reg, meas_next;
    logic [VAR_W-1:0]            pred_reg, pred_next;
    logic [DEN_W-1:0]            denom_reg, denom_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [GAIN_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [GAIN_W-1:0]           gain_reg, gain_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [EST_W-1:0]     est_new_reg, est_new_next;

    logic                        result_valid_reg, result_valid_next;
    logic [AXIS_W-1:0]           axis_out_reg, axis_out_next;
    logic signed [EST_W-1:0]     estimate_reg, estimate_next;
    logic [GAIN_W-1:0]           gain_out_reg, gain_out_next;

    // ------------------------------------------------------------------------
    // Combinational datapath signals.
    // ------------------------------------------------------------------------
    logic                        apb_write;
    logic                        meas_xfer;
    logic                        axis_ok;
    logic [AX_W-1:0]             ax_idx;
    logic signed [EST_W-1:0]     est_rd;
    logic [VAR_W-1:0]            cov_rd;
    logic [VAR_W:0]              pred_sum;
    logic [VAR_W-1:0]            pred_sat;
    logic [REM_W:0]              rem_sub;
    logic                        rem_ge;
    logic [REM_W-1:0]            rem_kept;
    logic [REM_W-1:0]            denom_x2;
    logic signed [DEN_W-1:0]     diff;
    logic [GAIN_W-1:0]           mul_a;
    logic [MUL_OPB_W-1:0]        mul_b;
    logic signed [GAIN_W:0]      mul_a_s;
    logic signed [HALF_W-1:0]    mul_b_s;
    logic signed [PROD_W-1:0]    prod;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     rnd;
    logic signed [ACC_W-1:0]     est_sum;
    logic [ACC_W-EST_W:0]        est_top;
    logic signed [EST_W-1:0]     est_sat;
    logic [VAR_W-1:0]            cov_sat;
    logic                        est_we;
    logic                        cov_we;
    logic                        out_free;

    // ------------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so every access takes exactly the setup and access cycles.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pn_reg <= PN_RESET;
            mn_reg <= MN_RESET;
        end
        else if (apb_write)
        begin
            unique case (skf3_reg_t'(paddr[2]))
                REG_PROCESS_NOISE:     pn_reg <= pwdata;
                REG_MEASUREMENT_NOISE: mn_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (skf3_reg_t'(paddr[2]))
            REG_PROCESS_NOISE:     prdata = pn_reg;
            REG_MEASUREMENT_NOISE: prdata = mn_reg;
        endcase
    end

    // ------------------------------------------------------------------------
    // Per-axis state. The selected axis is read at one address chosen by
    // the latched axis index; the estimate is written in the estimate step
    // and the covariance once the result is handed to the output register.
    // ------------------------------------------------------------------------
    assign ax_idx = AX_W'(axis_reg);
    assign est_rd = est_mem_reg[ax_idx];
    assign cov_rd = cov_mem_reg[ax_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                est_mem_reg[i] <= '0;
                cov_mem_reg[i] <= COV_RESET;
            end
        end
        else
        begin
            if (est_we)
            begin
                est_mem_reg[ax_idx] <= est_sat;
            end
            if (cov_we)
            begin
                cov_mem_reg[ax_idx] <= cov_sat;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Arithmetic.
    //
    // Prediction saturates the covariance plus the process noise at the
    // all-ones value. The gain comes from a restoring divider that produces
    // one quotient bit per cycle: the partial remainder starts at the
    // predicted variance and is compared against the full-width denominator
    // GAIN_W times, so the quotient never needs more than GAIN_W bits.
    // ------------------------------------------------------------------------
    assign pred_sum = {1'b0, cov_rd} + {1'b0, pn_reg};
    assign pred_sat = pred_sum[VAR_W] ? '1 : pred_sum[VAR_W-1:0];

    assign rem_sub  = {1'b0, rem_reg} - {2'b00, denom_reg};
    assign rem_ge   = !rem_sub[REM_W];
    assign rem_kept = rem_ge ? rem_sub[REM_W-1:0] : rem_reg;
    assign denom_x2 = {denom_reg, 1'b0};

    // Innovation: the measurement in Q16.16 less the current estimate.
    assign diff = {meas_reg[MEAS_W-1], meas_reg, 16'h0000} - {est_rd[EST_W-1], est_rd};

    // The shared multiplier. Operand A is unsigned, no more than one in
    // fixed point; operand B is a 34-bit signed value fed in two halves,
    // low half unsigned first, then the signed high half, accumulated with
    // a shift. The estimate pass multiplies the gain by the innovation and
    // the covariance pass multiplies one minus the gain by the prediction.
    always_comb
    begin
        if (state_reg == ST_MUL_C_LO || state_reg == ST_MUL_C_HI)
        begin
            mul_a = GAIN_ONE - gain_reg;
            mul_b = {2'b00, pred_reg};
        end
        else
        begin
            mul_a = gain_reg;
            mul_b = {diff[DEN_W-1], diff};
        end
    end

    assign mul_a_s = signed'({1'b0, mul_a});
    assign mul_b_s = (state_reg == ST_MUL_E_HI || state_reg == ST_MUL_C_HI)
                   ? signed'({mul_b[MUL_OPB_W-1], mul_b[MUL_OPB_W-1:MUL_SPLIT]})
                   : signed'({1'b0, mul_b[MUL_SPLIT-1:0]});
    assign prod     = mul_a_s * mul_b_s;
    assign prod_ext = ACC_W'(prod);

    // Round to nearest with ties toward plus infinity: add one half, then
    // an arithmetic shift floors the value.
    assign rnd     = (acc_reg + ROUND_HALF) >>> VAR_FRAC_BITS;
    assign est_sum = rnd + ACC_W'(est_rd);
    assign est_top = est_sum[ACC_W-1:EST_W-1];
    assign est_sat = ((&est_top) || !(|est_top)) ? est_sum[EST_W-1:0]
                   : (est_sum[ACC_W-1] ? {1'b1, {(EST_W-1){1'b0}}}
                                        : {1'b0, {(EST_W-1){1'b1}}});
    assign cov_sat = (|rnd[ACC_W-1:VAR_W]) ? '1 : rnd[VAR_W-1:0];

    // ------------------------------------------------------------------------
    // Sequencer. The block takes one item at a time; while an item is in
    // work the input is stalled. A finished result waits in the output
    // register, so a new item may start while the previous result has not
    // yet been transferred. An item whose axis is out of range is taken and
    // dropped without touching any state.
    // ------------------------------------------------------------------------
    assign meas_stall = (state_reg != ST_IDLE);
    assign meas_xfer  = meas_valid && !meas_stall;
    assign axis_ok    = (32'(axis) < 32'(NUM_AXES));
    assign out_free   = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg     <= axis_next;
        meas_reg     <= meas_next;
        pred_reg     <= pred_next;
        denom_reg    <= denom_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        gain_reg     <= gain_next;
        acc_reg      <= acc_next;
        est_new_reg  <= est_new_next;
        axis_out_reg <= axis_out_next;
        estimate_reg <= estimate_next;
        gain_out_reg <= gain_out_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        axis_next         = axis_reg;
        meas_next         = meas_reg;
        pred_next         = pred_reg;
        denom_next        = denom_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        cnt_next          = cnt_reg;
        gain_next         = gain_reg;
        acc_next          = acc_reg;
        est_new_next      = est_new_reg;
        axis_out_next     = axis_out_reg;
        estimate_next     = estimate_reg;
        gain_out_next     = gain_out_reg;
        est_we            = 1'b0;
        cov_we            = 1'b0;

        // A waiting result leaves the output register on its transfer.
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (meas_xfer && axis_ok)
                begin
                    axis_next  = axis;
                    meas_next  = measurement;
                    state_next = ST_PRED;
                end
            end
            ST_PRED:
            begin
                pred_next  = pred_sat;
                state_next = ST_DENOM;
            end
            ST_DENOM:
            begin
                denom_next = {1'b0, pred_reg} + {1'b0, mn_reg};
                rem_next   = {2'b00, pred_reg};
                quo_next   = '0;
                cnt_next   = DIV_LAST;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = {rem_kept[REM_W-2:0], 1'b0};
                quo_next = {quo_reg[GAIN_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // With a zero denominator the gain is defined as zero.
                    gain_next  = (denom_reg == '0) ? '0 : {quo_reg[GAIN_W-2:0], rem_ge};
                    state_next = ST_MUL_E_LO;
                end
            end
            ST_MUL_E_LO:
            begin
                acc_next   = prod_ext;
                state_next = ST_MUL_E_HI;
            end
            ST_MUL_E_HI:
            begin
                acc_next   = acc_reg + (prod_ext <<< MUL_SPLIT);
                state_next = ST_EST;
            end
            ST_EST:
            begin
                est_we       = 1'b1;
                est_new_next = est_sat;
                state_next   = ST_MUL_C_LO;
            end
            ST_MUL_C_LO:
            begin
                acc_next   = prod_ext;
                state_next = ST_MUL_C_HI;
            end
            ST_MUL_C_HI:
            begin
                acc_next   = acc_reg + (prod_ext <<< MUL_SPLIT);
                state_next = ST_COV;
            end
            ST_COV:
            begin
                // Hold here until the output register is free.
                if (out_free)
                begin
                    cov_we            = 1'b1;
                    axis_out_next     = axis_reg;
                    estimate_next     = est_new_reg;
                    gain_out_next     = gain_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign axis_out     = axis_out_reg;
    assign estimate     = estimate_reg;
    assign gain         = gain_out_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    `ASSERT_ALWAYS(a_gain_at_most_one,
        result_valid_reg |-> (gain_out_reg <= GAIN_ONE), "gain above one")
    `ASSERT_ALWAYS(a_div_rem_bound,
        (state_reg == ST_DIV && denom_reg != '0) |-> (rem_reg < denom_x2),
        "divider remainder out of bound")
    `ASSERT_NEXT(a_bad_axis_dropped, meas_xfer && !axis_ok, state_reg == ST_IDLE,
        "out-of-range axis started work")

endmodule

FILE: sim/skf3_checker.sv
// ----------------------------------------------------------------------------
// skf3_checker
// Watches the register port and both data channels of the three-axis Kalman
// filter. It keeps its own copy of the filter state, predicts the result of
// every accepted measurement on a valid axis and compares each result transfer with it.
// ----------------------------------------------------------------------------
module skf3_checker
    import skf3_pkg::*;
#(
    parameter int NUM_AXES      = 3,
    parameter int VAR_FRAC_BITS = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    input  logic [APB_DATA_W-1:0]    prdata,
    input  logic                     pready,

    input  logic                     meas_valid,
    input  logic                     meas_stall,
    input  logic [AXIS_W-1:0]        axis,
    input  logic signed [MEAS_W-1:0] measurement,

    input  logic                     result_valid,
    input  logic                     result_stall,
    input  logic [AXIS_W-1:0]        axis_out,
    input  logic signed [EST_W-1:0]  estimate,
    input  logic [VAR_FRAC_BITS:0]   gain,

    output int                       error_count,
    output int                       outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0]        VAR_ONE      = 64'd1 << VAR_FRAC_BITS;
    localparam logic [63:0]        VAR_HALF     = VAR_ONE >> 1;
    localparam logic signed [63:0] ROUND_HALF   = 64'sd1 <<< (VAR_FRAC_BITS - 1);
    localparam logic signed [63:0] EST_HI       = 64'sd2147483647;
    localparam logic signed [63:0] EST_LO       = -64'sd2147483648;
    localparam logic [31:0]        PN_DEFAULT   = 32'(VAR_ONE / 1000);
    localparam logic [31:0]        MN_DEFAULT   = 32'(VAR_ONE * 543 / 1000);
    localparam logic [31:0]        COV_DEFAULT  = 32'(VAR_ONE * 2 / 100);
    localparam logic [63:0]        VAR_CEILING  = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [AXIS_W-1:0]       axis;
        logic signed [EST_W-1:0] estimate;
        logic [VAR_FRAC_BITS:0]  gain;
    } filter_result_t;

    logic [VAR_W-1:0]        process_noise;
    logic [VAR_W-1:0]        measurement_noise;
    logic signed [EST_W-1:0] axis_est [NUM_AXES];
    logic [VAR_W-1:0]        axis_cov [NUM_AXES];
    filter_result_t          expected_results [$];
    int                      errors;

    // One filter step on the selected axis. Updates the local state and
    // returns the result that the block must deliver.
    function automatic filter_result_t kalman_update(input logic [AXIS_W-1:0] ax,
                                                     input logic signed [MEAS_W-1:0] m);
        logic [63:0]        pred;
        logic [63:0]        denom;
        logic [63:0]        g;
        logic [63:0]        cov;
        logic signed [63:0] m64;
        logic signed [63:0] e64;
        logic signed [63:0] diff;
        logic signed [63:0] corr;
        logic signed [63:0] est;
        filter_result_t     r;

        pred = {32'd0, axis_cov[ax]} + {32'd0, process_noise};
        if (pred > VAR_CEILING)
            pred = VAR_CEILING;
        denom = pred + {32'd0, measurement_noise};
        g = (denom == 64'd0) ? 64'd0 : (pred << VAR_FRAC_BITS) / denom;

        m64  = m;
        e64  = axis_est[ax];
        diff = m64 * 65536 - e64;
        // Arithmetic shift of the biased product gives round half up.
        corr = ($signed(g) * diff + ROUND_HALF) >>> VAR_FRAC_BITS;
        est  = e64 + corr;
        if (est > EST_HI)
            est = EST_HI;
        if (est < EST_LO)
            est = EST_LO;

        cov = ((VAR_ONE - g) * pred + VAR_HALF) >> VAR_FRAC_BITS;
        if (cov > VAR_CEILING)
            cov = VAR_CEILING;

        axis_est[ax] = est[EST_W-1:0];
        axis_cov[ax] = cov[VAR_W-1:0];

        r.axis     = ax;
        r.estimate = est[EST_W-1:0];
        r.gain     = g[VAR_FRAC_BITS:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t want;
        if (!rst_n)
        begin
            process_noise     = PN_DEFAULT;
            measurement_noise = MN_DEFAULT;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                axis_est[i] = '0;
                axis_cov[i] = COV_DEFAULT;
            end
            expected_results.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (skf3_reg_t'(paddr[2]))
                        REG_PROCESS_NOISE:     process_noise = pwdata;
                        REG_MEASUREMENT_NOISE: measurement_noise = pwdata;
                    endcase
                end
                else
                begin
                    case (skf3_reg_t'(paddr[2]))
                        REG_PROCESS_NOISE:     check_field("process_noise read",
                                                           process_noise, prdata);
                        REG_MEASUREMENT_NOISE: check_field("measurement_noise read",
                                                           measurement_noise, prdata);
                    endcase
                end
            end

            // Results are matched before new measurements are queued.
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, axis %0d estimate %h gain %h",
                             $time, axis_out, estimate, gain);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("axis_out", 32'(want.axis), 32'(axis_out));
                    check_field("estimate", want.estimate, estimate);
                    check_field("gain", 32'(want.gain), 32'(gain));
                end
            end

            if (meas_valid && !meas_stall && axis < NUM_AXES)
                expected_results.push_back(kalman_update(axis, measurement));
        end
        error_count <= errors;
        outstanding <= expected_results.size();
    end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the three-axis scalar Kalman filter. Register
// settings step through the extremes of both noise variances, measurement
// transfers come as directed edge cases and then random traffic, and both
// channels idle in random bursts. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
    import skf3_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_AXES        = 3;
    localparam int VAR_FRAC_BITS   = 24;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 155;
    // Extra settling wait after the last result has been delivered.
    localparam int SETTLE_CYCLES   = 2 * (VAR_FRAC_BITS + 11);
    localparam int LONG_HOLD       = 600;
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_W-1:0]       paddr;
    logic [APB_DATA_W-1:0]       pwdata;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;
    logic                        meas_valid;
    logic                        meas_stall;
    logic [AXIS_W-1:0]           axis;
    logic signed [MEAS_W-1:0]    measurement;
    logic                        result_valid;
    logic                        result_stall;
    logic [AXIS_W-1:0]           axis_out;
    logic signed [EST_W-1:0]     estimate;
    logic [VAR_FRAC_BITS:0]      gain;

    int                          checker_errors;
    int                          pending_results;

    // Idling controls shared by the sender and the receiver processes.
    int                          gap_pct;
    int                          stall_pct;
    bit                          long_hold_req;

    // Slowly drifting level per axis, so that some traffic looks like a
    // real sensor signal that the filter can settle on.
    logic signed [MEAS_W-1:0]    signal_level [NUM_AXES];

    scalar_kalman_filter_three_axis #(
        .NUM_AXES      (NUM_AXES),
        .VAR_FRAC_BITS (VAR_FRAC_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .meas_valid   (meas_valid),
        .meas_stall   (meas_stall),
        .axis         (axis),
        .measurement  (measurement),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .axis_out     (axis_out),
        .estimate     (estimate),
        .gain         (gain)
    );

    skf3_checker #(
        .NUM_AXES      (NUM_AXES),
        .VAR_FRAC_BITS (VAR_FRAC_BITS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .meas_valid   (meas_valid),
        .meas_stall   (meas_stall),
        .axis         (axis),
        .measurement  (measurement),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .axis_out     (axis_out),
        .estimate     (estimate),
        .gain         (gain),
        .error_count  (checker_errors),
        .outstanding  (pending_results)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One register access: a setup cycle, then the access cycle, which ends
    // at the edge where pready is high. The extra edge at the end keeps two
    // back-to-back accesses from assigning psel twice in one time step.
    task automatic apb_access(input logic wr, input skf3_reg_t which,
                              input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes both noise registers and reads them back; the checker compares
    // the read data with its own copy.
    task automatic set_noise(input logic [31:0] pn, input logic [31:0] mn);
        apb_access(1'b1, REG_PROCESS_NOISE, pn);
        apb_access(1'b1, REG_MEASUREMENT_NOISE, mn);
        apb_access(1'b0, REG_PROCESS_NOISE, '0);
        apb_access(1'b0, REG_MEASUREMENT_NOISE, '0);
    endtask

    // Offers one measurement and holds it until the transfer happens. Valid
    // stays high into the next item unless a random gap follows.
    task automatic send_item(input logic [AXIS_W-1:0] ax,
                             input logic signed [MEAS_W-1:0] m);
        meas_valid  <= 1'b1;
        axis        <= ax;
        measurement <= m;
        do
            @(posedge clk);
        while (meas_stall);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            meas_valid  <= 1'b0;
            measurement <= MEAS_W'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    function automatic logic signed [MEAS_W-1:0] pick_measurement(input int ax);
        logic signed [MEAS_W-1:0] m;
        case ($urandom_range(0, 3))
            0: m = MEAS_W'($urandom);
            1: m = $signed(16'($urandom_range(0, 511))) - 16'sd256;
            2: m = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:
            begin
                if (ax < NUM_AXES)
                begin
                    signal_level[ax] = signal_level[ax] + $signed(16'($urandom_range(0, 64)))
                                       - 16'sd32;
                    m = signal_level[ax] + $signed(16'($urandom_range(0, 16))) - 16'sd8;
                end
                else
                    m = MEAS_W'($urandom);
            end
        endcase
        return m;
    endfunction

    // Mostly valid axes; an occasional out-of-range axis must be dropped.
    task automatic send_random_item();
        int ax;
        ax = ($urandom_range(0, 15) == 0) ? NUM_AXES : $urandom_range(0, NUM_AXES - 1);
        send_item(AXIS_W'(ax), pick_measurement(ax));
    endtask

    // Lowers valid, waits until every predicted result has been delivered,
    // then waits out a further settling time.
    task automatic wait_drained();
        meas_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver side. Stalls come in short random bursts, or once as a long
    // hold-off while the sender keeps offering, so that the block backs up
    // and stalls its own input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                for (int hold = 0; hold < LONG_HOLD; hold++)
                    @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for
    // too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((meas_valid && !meas_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Main stimulus sequence.
    initial
    begin
        logic [31:0] pn;
        logic [31:0] mn;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        meas_valid    = 1'b0;
        axis          = '0;
        measurement   = '0;
        result_stall  = 1'b0;
        gap_pct       = 20;
        stall_pct     = 20;
        long_hold_req = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
            signal_level[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset values of both registers must read back.
        apb_access(1'b0, REG_PROCESS_NOISE, '0);
        apb_access(1'b0, REG_MEASUREMENT_NOISE, '0);

        // Directed part at the reset setting: measurement extremes on axes 0 and 1,
        // large swings, alternating bit patterns, and transfers on the
        // out-of-range axis that must produce nothing.
        send_item(2'd0, 16'sh7FFF);
        send_item(2'd1, 16'sh8000);
        send_item(2'd2, 16'sh0000);
        send_item(2'd3, 16'sh7FFF);
        send_item(2'd3, 16'sh8000);
        send_item(2'd0, 16'sh8000);
        send_item(2'd1, 16'sh7FFF);
        send_item(2'd2, 16'sh5555);
        send_item(2'd2, 16'shAAAA);
        send_item(2'd0, 16'sh0001);
        send_item(2'd1, 16'shFFFF);
        send_item(2'd2, 16'shFFFF);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Registers change only with the block idle.
            wait_drained();
            case (phase)
                // No noise at all: the first step on each axis has a gain of
                // exactly one, after which the covariance is zero and the
                // denominator becomes zero.
                0: begin pn = 32'h0000_0000; mn = 32'h0000_0000; end
                // Both at full scale: the predicted variance saturates.
                1: begin pn = 32'hFFFF_FFFF; mn = 32'hFFFF_FFFF; end
                2: begin pn = 32'hFFFF_FFFF; mn = 32'h0000_0000; end
                3: begin pn = 32'h0000_0000; mn = 32'hFFFF_FFFF; end
                4: begin pn = $urandom_range(0, 1 << 24); mn = $urandom_range(0, 1 << 25); end
                5: begin pn = $urandom; mn = $urandom; end
                // Back to the power-on tuning for a final clean stretch.
                default: begin pn = 32'd16777; mn = 32'd9110028; end
            endcase
            set_noise(pn, mn);

            // Idling varies by phase, with some phases free of it; the last
            // phase has none on either side.
            if (phase == NUM_PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end

            // Once in the run, the receiver holds off for a long stretch
            // while transfers keep being offered.
            if (phase == 4)
                long_hold_req = 1'b1;

            for (int a = 0; a < NUM_AXES; a++)
                send_item(AXIS_W'(a), (phase % 2 == 0) ? 16'sh7FFF : 16'sh8000);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_item();
        end

        wait_drained();
        if (checker_errors == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
